// ----- hdl/dsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and constants of the delta-stepping relax engine.
// ----------------------------------------------------------------------------
package dsr_pkg;
	localparam int VERTICES = 1024;
	localparam int VW = $clog2(VERTICES);
	localparam int DW = 31;
	localparam int PW = 11;
	localparam logic [DW-1:0] INF_DIST = {DW{1'b1}};
	localparam logic [PW-1:0] NO_PARENT = {PW{1'b1}};

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_RELAX = 3'd1,
		CMD_POP = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_ADVANCE = 3'd4,
		CMD_READ = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_SRC,
		ST_RD_DST,
		ST_DIV,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DW-1:0] quotient;
	} div_rsp_t;
endpackage

// ----- hdl/delta_stepping_relax_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_stepping_relax_engine
// Per-vertex distance, parent and bucket store for delta-stepping SSSP.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: cmd, vertex, edge_dest, edge_weight
// m_axis    out  tdata: relaxed, popped, distance, parent, pending_count,
//                current_bucket, bucket_flag
// cfg       in   bucket_width
// Start goes from reading the source straight to output; pop, clear, advance,
// read and the unused codes read the vertex, pass the write state and output;
// a relax reads source and destination and outputs if it does not improve;
// an improving relax waits for the 31-step divider, then writes and outputs.
// The next item is taken in the cycle after the result leaves. After reset a
// clearing pass sweeps all 1024 entries of the store; no item is taken meanwhile. A stalled output item holds.
// ----------------------------------------------------------------------------
module delta_stepping_relax_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// cmd[2:0], vertex[12:3], edge_dest[22:13], edge_weight[53:23]
	input  logic [55:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// relaxed[0], popped[1], distance[32:2], parent[43:33],
	// pending_count[54:44], current_bucket[85:55], bucket_flag[86]
	output logic [87:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [30:0] cfg_wdata
);
	import dsr_pkg::*;

	localparam int EW = DW + PW + DW;

	logic [EW-1:0] mem [VERTICES];
	logic [EW-1:0] rdata_q;
	logic [VW-1:0] raddr;
	logic [VW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic we;
	logic re;

	state_t state_q, state_d;
	logic [VW:0] clr_q;
	logic [2:0] cmd_q;
	logic [VW-1:0] v_q;
	logic [VW-1:0] d_q;
	logic [DW-1:0] w_q;
	logic [DW:0] nd_q;
	logic [DW-1:0] width_q;
	logic [PW-1:0] pend_q;
	logic [DW-1:0] bnow_q;
	logic flag_q;
	logic relaxed_q;
	logic popped_q;
	logic ovalid_q;
	logic improve;

	div_req_t dreq;
	div_rsp_t drsp;

	logic [DW-1:0] rd_dist;
	logic [PW-1:0] rd_par;
	logic [DW-1:0] rd_bkt;
	assign rd_dist = rdata_q[EW-1 -: DW];
	assign rd_par = rdata_q[DW +: PW];
	assign rd_bkt = rdata_q[DW-1:0];

	dsr_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	logic [DW:0] sum;
	assign sum = {1'b0, rd_dist} + {1'b0, w_q};

	// pulse on entry to the divide state
	logic div_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_go_q <= 1'b0;
		else
			div_go_q <= (state_q == ST_RD_DST);
	end

	assign improve = !nd_q[DW] && (nd_q[DW-1:0] < rd_dist);

	always_comb begin
		state_d = state_q;
		re = 1'b0;
		raddr = v_q;
		we = 1'b0;
		waddr = d_q;
		wdata = {INF_DIST, NO_PARENT, INF_DIST};
		dreq.start = 1'b0;
		dreq.dividend = nd_q[DW-1:0];
		dreq.divisor = width_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q[VW-1:0];
				if (clr_q == (VW+1)'(VERTICES - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_axis_tready = !ovalid_q;
				if (s_axis_tvalid && !ovalid_q)
					state_d = ST_RD_SRC;
			end
			ST_RD_SRC: begin
				re = 1'b1;
				raddr = v_q;
				unique case (cmd_q)
					CMD_START: begin
						we = 1'b1;
						waddr = v_q;
						wdata = {DW'(0), PW'(v_q), DW'(0)};
						state_d = ST_OUT;
					end
					CMD_RELAX: state_d = ST_RD_DST;
					default: state_d = ST_WRITE;
				endcase
			end
			ST_RD_DST: begin
				re = 1'b1;
				raddr = d_q;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				dreq.start = div_go_q && improve;
				if (!improve) begin
					state_d = ST_OUT;
				end else if (drsp.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (cmd_q == CMD_RELAX) begin
					we = 1'b1;
					waddr = d_q;
					wdata = {nd_q[DW-1:0], PW'(v_q), quo_hold_q};
				end else if (cmd_q == CMD_POP && rd_bkt != INF_DIST && rd_bkt == bnow_q) begin
					we = 1'b1;
					waddr = v_q;
					wdata = {rd_dist, rd_par, INF_DIST};
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				re = 1'b1;
				raddr = (cmd_q == CMD_RELAX) ? d_q : v_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	logic [DW-1:0] quo_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			width_q <= DW'(1);
			pend_q <= '0;
			bnow_q <= '0;
			flag_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (cfg_we)
				width_q <= cfg_wdata;
			if (m_axis_tvalid && m_axis_tready)
				ovalid_q <= 1'b0;
			if (state_q == ST_RD_SRC) begin
				unique case (cmd_q)
					CMD_START: begin
						pend_q <= PW'(1);
						bnow_q <= '0;
						flag_q <= 1'b1;
					end
					CMD_CLEAR: flag_q <= 1'b0;
					CMD_ADVANCE: bnow_q <= bnow_q + DW'(1);
					default: ;
				endcase
			end
			if (state_q == ST_WRITE) begin
				if (cmd_q == CMD_RELAX) begin
					if (rd_bkt == INF_DIST && pend_q != NO_PARENT)
						pend_q <= pend_q + 1'b1;
					if (quo_hold_q == bnow_q)
						flag_q <= 1'b1;
				end else if (cmd_q == CMD_POP && rd_bkt != INF_DIST
						&& rd_bkt == bnow_q && pend_q != '0)
					pend_q <= pend_q - 1'b1;
			end
			if (state_q == ST_OUT)
				ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q <= s_axis_tdata[2:0];
			v_q <= s_axis_tdata[12:3];
			d_q <= s_axis_tdata[22:13];
			w_q <= s_axis_tdata[53:23];
			relaxed_q <= 1'b0;
			popped_q <= 1'b0;
		end
		if (state_q == ST_RD_DST)
			nd_q <= sum;
		if (drsp.done)
			quo_hold_q <= drsp.quotient;
		if (state_q == ST_WRITE) begin
			relaxed_q <= (cmd_q == CMD_RELAX);
			popped_q <= (cmd_q == CMD_POP && rd_bkt != INF_DIST && rd_bkt == bnow_q);
		end
	end

	logic [DW-1:0] o_dist;
	logic [PW-1:0] o_par;
	assign o_dist = rd_dist;
	assign o_par = rd_par;

	logic [87:0] res;
	assign res = {1'b0, flag_q, bnow_q, pend_q, o_par, o_dist, popped_q, relaxed_q};
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = res;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_axis_tready) else $error("item taken during clear");
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE && cmd_q == CMD_CLEAR |=> $stable(pend_q))
		else $error("pending changed");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !ovalid_q) else $error("overrun");
endmodule

// ----- hdl/dsr_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsr_divider (
	input  logic clk,
	input  logic arst_n,
	input  dsr_pkg::div_req_t req,
	output dsr_pkg::div_rsp_t rsp
);
	import dsr_pkg::*;

	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DW:0] trial;
	logic [DW:0] diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= (req.divisor == '0) ? DW'(1) : req.divisor;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q && cnt_q == 5'(DW - 1)) else $error("divider start");
endmodule
